// ===== hdl/slpbm_pkg.sv =====
// ----------------------------------------------------------------------------
// slpbm_pkg
// Shared types and constants for the serial-loaded program bank mapper.
// ----------------------------------------------------------------------------
package slpbm_pkg;

  localparam int DEFAULT_MAX_PRG_BANKS = 16;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // configuration register indexes (paddr bit 2)
  localparam logic REG_BANKED_ON  = 1'b0;
  localparam logic REG_BANK_COUNT = 1'b1;

  // request kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // target register, from address bits 14:13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  // PRG modes, control bits 3:2
  localparam logic [1:0] MODE_32K_A   = 2'd0;
  localparam logic [1:0] MODE_32K_B   = 2'd1;
  localparam logic [1:0] MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] CONTROL_RESET = 5'h0C;
  localparam logic [4:0] CONTROL_FORCE = 5'h0C;
  localparam logic [2:0] SERIAL_LAST   = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  data;
  } in_req_t;

  typedef struct packed {
    logic [17:0] rom_offset;
    logic [4:0]  control_value;
    logic [4:0]  chr_bank_first;
    logic [4:0]  chr_bank_second;
    logic [4:0]  prg_bank_value;
  } out_rsp_t;

endpackage

// ===== hdl/serial_loaded_prg_bank_mapper.sv =====
// ----------------------------------------------------------------------------
// serial_loaded_prg_bank_mapper
// Serial-loaded PRG bank mapper: shifts CPU writes into the mapper registers
// and translates CPU reads in 0x8000..0xFFFF into program ROM offsets.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in_       sink       in_valid / in_stall     in_req  (kind, address, data)
//   out_      source     out_valid / out_stall   out_rsp (offset, registers)
//   cfg (APB) sink       psel/penable/pwrite     paddr, pwdata, prdata
//
// One request per cycle sustained while out_ does not stall. A request is
// held in the input register, then the mapper state and the result register
// update together. rst_n (synchronous, active low) clears both valid flags
// and restores the register reset values. A stall on out_ holds the result;
// in_stall rises only when both the input register and the result register
// are full and the result is stalled.
// ----------------------------------------------------------------------------
module serial_loaded_prg_bank_mapper
  import slpbm_pkg::*;
#(
  parameter int MAX_PRG_BANKS = DEFAULT_MAX_PRG_BANKS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_rsp_t          out_rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [4:0] MAX_BANKS    = 5'(MAX_PRG_BANKS);
  localparam logic [4:0] MAX_BANKS_M1 = 5'(MAX_PRG_BANKS - 1);

  // configuration
  logic       banked_on_r;
  logic [4:0] bank_count_r;

  // mapper state
  logic [4:0] shift_r,   shift_nxt;
  logic [2:0] count_r,   count_nxt;
  logic [4:0] control_r, control_nxt;
  logic [4:0] chr0_r,    chr0_nxt;
  logic [4:0] chr1_r,    chr1_nxt;
  logic [4:0] prg_r,     prg_nxt;

  // pipeline
  logic     s1_valid_r;
  in_req_t  s1_req_r;
  logic     out_valid_r;
  out_rsp_t out_rsp_r, out_rsp_nxt;

  logic advance;
  logic in_take;
  logic s1_move;

  // ---------------------------------------------------------------- APB port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      banked_on_r  <= 1'b1;
      bank_count_r <= 5'd2;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BANKED_ON:  banked_on_r  <= pwdata[0];
        REG_BANK_COUNT: bank_count_r <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BANKED_ON:  prdata = {{(CFG_DW-1){1'b0}}, banked_on_r};
      REG_BANK_COUNT: prdata = {{(CFG_DW-5){1'b0}}, bank_count_r};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------- handshake
  // Advance whenever the result register is empty or is being taken.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Hold the request while it waits; load a new one when accepted.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_req;
    end
  end

  // ----------------------------------------------------- serial write update
  logic       in_window;
  logic       do_write;
  logic [4:0] shift_in;

  assign in_window = s1_req_r.address[15];
  assign do_write  = (s1_req_r.kind == KIND_WRITE) && in_window && banked_on_r;
  assign shift_in  = {s1_req_r.data[0], shift_r[4:1]};

  always_comb begin
    shift_nxt   = shift_r;
    count_nxt   = count_r;
    control_nxt = control_r;
    chr0_nxt    = chr0_r;
    chr1_nxt    = chr1_r;
    prg_nxt     = prg_r;
    if (do_write) begin
      if (s1_req_r.data[7]) begin
        // reset write: drop the partial value, force last-bank-fixed mode
        shift_nxt   = '0;
        count_nxt   = '0;
        control_nxt = control_r | CONTROL_FORCE;
      end else if (count_r >= SERIAL_LAST) begin
        // fifth bit: commit to the register picked by the address range
        shift_nxt = '0;
        count_nxt = '0;
        case (s1_req_r.address[14:13])
          SEL_CONTROL: control_nxt = shift_in;
          SEL_CHR0:    chr0_nxt    = shift_in;
          SEL_CHR1:    chr1_nxt    = shift_in;
          SEL_PRG:     prg_nxt     = shift_in;
          default: ;
        endcase
      end else begin
        shift_nxt = shift_in;
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r   <= '0;
      count_r   <= '0;
      control_r <= CONTROL_RESET;
      chr0_r    <= '0;
      chr1_r    <= '0;
      prg_r     <= '0;
    end else if (s1_move) begin
      shift_r   <= shift_nxt;
      count_r   <= count_nxt;
      control_r <= control_nxt;
      chr0_r    <= chr0_nxt;
      chr1_r    <= chr1_nxt;
      prg_r     <= prg_nxt;
    end
  end

  // ------------------------------------------------------- read translation
  logic [4:0]  last_bank;
  logic [3:0]  bank;
  logic [14:0] rel;
  logic [13:0] low14;
  logic        upper_half;
  logic [17:0] offset;

  // Saturate the bank count to 1..MAX_PRG_BANKS and take the last bank index.
  always_comb begin
    if (bank_count_r == 5'd0) begin
      last_bank = 5'd0;
    end else if (bank_count_r > MAX_BANKS) begin
      last_bank = MAX_BANKS_M1;
    end else begin
      last_bank = bank_count_r - 5'd1;
    end
  end

  assign bank       = prg_r[3:0];
  assign rel        = s1_req_r.address[14:0];
  assign low14      = s1_req_r.address[13:0];
  assign upper_half = s1_req_r.address[14];

  always_comb begin
    offset = '0;
    if ((s1_req_r.kind == KIND_READ) && in_window) begin
      if (banked_on_r) begin
        case (control_r[3:2])
          MODE_FIX_FIRST: begin
            offset = upper_half ? {bank, low14} : {3'b000, rel};
          end
          MODE_FIX_LAST: begin
            offset = upper_half ? {last_bank[3:0], low14}
                                : {bank, 14'b0} + {3'b000, rel};
          end
          default: begin
            offset = {bank[3:1], rel};
          end
        endcase
      end else begin
        // plain mapping, mirrored to 16 KB on a single-bank cartridge
        offset = {3'b000, rel};
        if (last_bank == 5'd0) begin
          offset[14] = 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------- result register
  always_comb begin
    out_rsp_nxt.rom_offset      = offset;
    out_rsp_nxt.control_value   = control_nxt;
    out_rsp_nxt.chr_bank_first  = chr0_nxt;
    out_rsp_nxt.chr_bank_second = chr1_nxt;
    out_rsp_nxt.prg_bank_value  = prg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// ===== hdl/slpbm_checker.sv =====
// ----------------------------------------------------------------------------
// slpbm_checker
// Port-level checks for the serial-loaded PRG bank mapper, bound to the top.
// ----------------------------------------------------------------------------
module slpbm_checker
  import slpbm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input out_rsp_t          out_rsp,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [CFG_DW-1:0] pwdata,
  input logic [CFG_DW-1:0] prdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed or dropped");

  // with the result register empty the input side never stalls
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a mode write reads back on the following cycle
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[2] == REG_BANKED_ON)
    |=> (paddr[2] != REG_BANKED_ON) || (prdata[0] == $past(pwdata[0])))
    else $error("banked mode readback mismatch");

endmodule

bind serial_loaded_prg_bank_mapper slpbm_checker u_slpbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
